/* rtl/assert_macros.svh */
// Assertion macros shared by the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/nv12pfc_pkg.sv */
// Types and constants of the NV12 pixel format converter.
package nv12pfc_pkg;

    typedef enum logic [1:0] {
        FMT_ARGB   = 2'd0,
        FMT_RGBA   = 2'd1,
        FMT_UYVY   = 2'd2,
        FMT_PLANAR = 2'd3
    } t_fmt;

    localparam logic [0:0] CFG_OUT_FORMAT  = 1'b0;
    localparam logic [0:0] CFG_ALPHA_VALUE = 1'b1;

    localparam logic [7:0] ALPHA_RESET = 8'hFF;
    localparam logic [7:0] BYTE_MAX    = 8'hFF;

    localparam logic signed [8:0]  LUMA_OFFSET   = 9'sd16;
    localparam logic signed [8:0]  CHROMA_OFFSET = 9'sd128;
    localparam logic signed [17:0] COEF_Y   = 18'sd298;
    localparam logic signed [17:0] COEF_RV  = 18'sd409;
    localparam logic signed [17:0] COEF_GU  = 18'sd100;
    localparam logic signed [17:0] COEF_GV  = 18'sd208;
    localparam logic signed [17:0] COEF_BU  = 18'sd516;
    localparam logic signed [18:0] ROUND_HALF = 19'sd128;

    typedef struct packed {
        logic signed [17:0] r_term;
        logic signed [17:0] g_term;
        logic signed [17:0] b_term;
    } t_chroma_terms;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    typedef struct packed {
        logic [7:0] y0;
        logic [7:0] y1;
        logic [7:0] u;
        logic [7:0] v;
    } t_yuv;

    typedef struct packed {
        logic row_last;
        logic frame_last;
        logic even_row;
    } t_ctl;

endpackage

/* rtl/nv12_pixel_format_converter.sv */
// Top level of the NV12 pixel format converter.
//
// The input channel (i_valid, o_stall) carries one horizontal pixel pair per
// item: two luma bytes, the shared Cb and Cr bytes and the row and frame end
// markers. The output channel (o_valid, i_stall) returns one result item for
// each input item, in order, as ARGB, RGBA, packed UYVY or planar words.
// Throughput is one pixel pair per clock while the output is not stalled.
// After acceptance, the product stage registers the luma and chroma
// products; the output register then holds the summed, clamped and packed
// result and drives o_valid. The product stage and the output register each
// hold one item and move whenever the stage after them is empty or is being
// emptied, so the block keeps taking items while a result waits, until both
// stages are full. If the receiver stalls, the output register holds its
// result and o_stall rises once the product stage is also occupied.
// The synchronous active-low reset empties the pipeline, selects ARGB with an
// alpha of 255 and marks the next row as even. Configuration writes are to be
// made only while the block is idle; the block itself does not enforce this.
`include "assert_macros.svh"

module nv12_pixel_format_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [0:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_luma0,
    input  logic [7:0]  i_luma1,
    input  logic [7:0]  i_chroma_u,
    input  logic [7:0]  i_chroma_v,
    input  logic        i_row_last,
    input  logic        i_frame_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_first_word,
    output logic [31:0] o_second_word,
    output logic [1:0]  o_word_count,
    output logic        o_chroma_valid,
    output logic        o_row_done,
    output logic        o_frame_done
);

    nv12pfc_pkg::t_fmt          r_out_format;
    logic [7:0]                 r_alpha_value;
    logic                       r_odd_row;
    logic                       r_p_valid;
    logic                       r_o_valid;
    nv12pfc_pkg::t_yuv          r_p_yuv;
    nv12pfc_pkg::t_ctl          r_p_ctl;
    logic                       en_p;
    logic                       en_o;
    logic                       accept;
    nv12pfc_pkg::t_chroma_terms chroma_terms;
    nv12pfc_pkg::t_rgb          px0;
    nv12pfc_pkg::t_rgb          px1;

    assign en_o    = !r_o_valid || !i_stall;
    assign en_p    = !r_p_valid || en_o;
    assign accept  = i_valid && en_p;
    assign o_stall = !en_p;
    assign o_valid = r_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_format  <= nv12pfc_pkg::FMT_ARGB;
            r_alpha_value <= nv12pfc_pkg::ALPHA_RESET;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == nv12pfc_pkg::CFG_OUT_FORMAT) begin
                r_out_format <= nv12pfc_pkg::t_fmt'(i_cfg_data[1:0]);
            end
            if (i_cfg_index == nv12pfc_pkg::CFG_ALPHA_VALUE) begin
                r_alpha_value <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_odd_row <= 1'b0;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (accept) begin
                if (i_frame_last) begin
                    r_odd_row <= 1'b0;
                end else if (i_row_last) begin
                    r_odd_row <= !r_odd_row;
                end
            end
            if (en_p) begin
                r_p_valid <= i_valid;
            end
            if (en_o) begin
                r_o_valid <= r_p_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_p) begin
            r_p_yuv <= '{y0: i_luma0, y1: i_luma1, u: i_chroma_u, v: i_chroma_v};
            r_p_ctl <= '{row_last: i_row_last, frame_last: i_frame_last,
                         even_row: !r_odd_row};
        end
    end

    nv12pfc_chroma u_chroma (
        .i_clk      (i_clk),
        .i_load     (en_p),
        .i_chroma_u (i_chroma_u),
        .i_chroma_v (i_chroma_v),
        .o_terms    (chroma_terms)
    );

    nv12pfc_lane u_lane0 (
        .i_clk   (i_clk),
        .i_load  (en_p),
        .i_luma  (i_luma0),
        .i_terms (chroma_terms),
        .o_rgb   (px0)
    );

    nv12pfc_lane u_lane1 (
        .i_clk   (i_clk),
        .i_load  (en_p),
        .i_luma  (i_luma1),
        .i_terms (chroma_terms),
        .o_rgb   (px1)
    );

    nv12pfc_merge u_merge (
        .i_clk          (i_clk),
        .i_load         (en_o && r_p_valid),
        .i_fmt          (r_out_format),
        .i_alpha        (r_alpha_value),
        .i_px0          (px0),
        .i_px1          (px1),
        .i_yuv          (r_p_yuv),
        .i_ctl          (r_p_ctl),
        .o_first_word   (o_first_word),
        .o_second_word  (o_second_word),
        .o_word_count   (o_word_count),
        .o_chroma_valid (o_chroma_valid),
        .o_row_done     (o_row_done),
        .o_frame_done   (o_frame_done)
    );

    `ASSERT_NEXT(a_frame_end_even, i_clk, i_rst_n, accept && i_frame_last, !r_odd_row)
    `ASSERT_IMPLIES(a_rgb_two_words, i_clk, i_rst_n, o_valid && (r_out_format == nv12pfc_pkg::FMT_ARGB || r_out_format == nv12pfc_pkg::FMT_RGBA), o_word_count == 2'd2)
    `ASSERT_IMPLIES(a_yuv_one_word, i_clk, i_rst_n, o_valid && (r_out_format == nv12pfc_pkg::FMT_UYVY || r_out_format == nv12pfc_pkg::FMT_PLANAR), o_word_count == 2'd1 && o_second_word == 32'd0)
    `ASSERT_IMPLIES(a_chroma_planar_only, i_clk, i_rst_n, o_valid && o_chroma_valid, r_out_format == nv12pfc_pkg::FMT_PLANAR)

endmodule

/* rtl/nv12pfc_chroma.sv */
// Shared chroma term unit: registers the Cb and Cr products used by both lanes.
module nv12pfc_chroma (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic [7:0]                    i_chroma_u,
    input  logic [7:0]                    i_chroma_v,
    output nv12pfc_pkg::t_chroma_terms    o_terms
);

    logic signed [8:0]  d9;
    logic signed [8:0]  e9;
    logic signed [17:0] d18;
    logic signed [17:0] e18;
    nv12pfc_pkg::t_chroma_terms n_terms;
    nv12pfc_pkg::t_chroma_terms r_terms;

    always_comb begin
        d9 = $signed({1'b0, i_chroma_u}) - nv12pfc_pkg::CHROMA_OFFSET;
        e9 = $signed({1'b0, i_chroma_v}) - nv12pfc_pkg::CHROMA_OFFSET;
        d18 = 18'(d9);
        e18 = 18'(e9);
        n_terms.r_term = e18 * nv12pfc_pkg::COEF_RV;
        n_terms.g_term = -(d18 * nv12pfc_pkg::COEF_GU) - (e18 * nv12pfc_pkg::COEF_GV);
        n_terms.b_term = d18 * nv12pfc_pkg::COEF_BU;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_terms <= n_terms;
        end
    end

    assign o_terms = r_terms;

endmodule

/* rtl/nv12pfc_lane.sv */
// One pixel lane: registers the luma product, then adds chroma terms and clamps.
module nv12pfc_lane (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic [7:0]                    i_luma,
    input  nv12pfc_pkg::t_chroma_terms    i_terms,
    output nv12pfc_pkg::t_rgb             o_rgb
);

    logic signed [8:0]  c9;
    logic signed [17:0] n_luma_term;
    logic signed [17:0] r_luma_term;
    logic signed [18:0] sum_r;
    logic signed [18:0] sum_g;
    logic signed [18:0] sum_b;

    function automatic logic [7:0] sat_byte(input logic signed [18:0] acc);
        logic [7:0] res;
        if (acc[18]) begin
            res = 8'd0;
        end else if (acc[17] || acc[16]) begin
            res = nv12pfc_pkg::BYTE_MAX;
        end else begin
            res = acc[15:8];
        end
        return res;
    endfunction

    always_comb begin
        c9 = $signed({1'b0, i_luma}) - nv12pfc_pkg::LUMA_OFFSET;
        n_luma_term = 18'(c9) * nv12pfc_pkg::COEF_Y;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_luma_term <= n_luma_term;
        end
    end

    always_comb begin
        sum_r = 19'(r_luma_term) + 19'(i_terms.r_term) + nv12pfc_pkg::ROUND_HALF;
        sum_g = 19'(r_luma_term) + 19'(i_terms.g_term) + nv12pfc_pkg::ROUND_HALF;
        sum_b = 19'(r_luma_term) + 19'(i_terms.b_term) + nv12pfc_pkg::ROUND_HALF;
        o_rgb.r = sat_byte(sum_r);
        o_rgb.g = sat_byte(sum_g);
        o_rgb.b = sat_byte(sum_b);
    end

endmodule

/* rtl/nv12pfc_merge.sv */
// Merge stage: packs the lane results or the raw samples into the output register.
module nv12pfc_merge (
    input  logic                  i_clk,
    input  logic                  i_load,
    input  nv12pfc_pkg::t_fmt     i_fmt,
    input  logic [7:0]            i_alpha,
    input  nv12pfc_pkg::t_rgb     i_px0,
    input  nv12pfc_pkg::t_rgb     i_px1,
    input  nv12pfc_pkg::t_yuv     i_yuv,
    input  nv12pfc_pkg::t_ctl     i_ctl,
    output logic [31:0]           o_first_word,
    output logic [31:0]           o_second_word,
    output logic [1:0]            o_word_count,
    output logic                  o_chroma_valid,
    output logic                  o_row_done,
    output logic                  o_frame_done
);

    logic [7:0]  alpha;
    logic [31:0] n_first_word;
    logic [31:0] n_second_word;
    logic [1:0]  n_word_count;
    logic        n_chroma_valid;
    logic [31:0] r_first_word;
    logic [31:0] r_second_word;
    logic [1:0]  r_word_count;
    logic        r_chroma_valid;
    logic        r_row_done;
    logic        r_frame_done;

    always_comb begin
        alpha = (i_alpha == 8'd0) ? nv12pfc_pkg::BYTE_MAX : i_alpha;
        n_first_word   = 32'd0;
        n_second_word  = 32'd0;
        n_word_count   = 2'd1;
        n_chroma_valid = 1'b0;
        case (i_fmt)
            nv12pfc_pkg::FMT_ARGB: begin
                n_first_word  = {alpha, i_px0.r, i_px0.g, i_px0.b};
                n_second_word = {alpha, i_px1.r, i_px1.g, i_px1.b};
                n_word_count  = 2'd2;
            end
            nv12pfc_pkg::FMT_RGBA: begin
                n_first_word  = {i_px0.r, i_px0.g, i_px0.b, alpha};
                n_second_word = {i_px1.r, i_px1.g, i_px1.b, alpha};
                n_word_count  = 2'd2;
            end
            nv12pfc_pkg::FMT_UYVY: begin
                n_first_word = {i_yuv.u, i_yuv.y0, i_yuv.v, i_yuv.y1};
            end
            default: begin
                n_first_word   = {i_yuv.y0, i_yuv.y1, i_yuv.u, i_yuv.v};
                n_chroma_valid = i_ctl.even_row;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_first_word   <= n_first_word;
            r_second_word  <= n_second_word;
            r_word_count   <= n_word_count;
            r_chroma_valid <= n_chroma_valid;
            r_row_done     <= i_ctl.row_last;
            r_frame_done   <= i_ctl.frame_last;
        end
    end

    assign o_first_word   = r_first_word;
    assign o_second_word  = r_second_word;
    assign o_word_count   = r_word_count;
    assign o_chroma_valid = r_chroma_valid;
    assign o_row_done     = r_row_done;
    assign o_frame_done   = r_frame_done;

endmodule
